[hdl/apxo_pkg.sv]
// Shared types, constants, sequence table and arithmetic helpers for the crossover core.
package apxo_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 18;
  localparam int CFRAC       = COEF_BITS - 2;
  localparam int CREG_BITS   = 3 * COEF_BITS;
  localparam int ACC_BITS    = 32;
  localparam int PROD_BITS   = ACC_BITS + COEF_BITS;   // full product width
  localparam int RND_BITS    = PROD_BITS - CFRAC;      // rounded product width

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] band1_left;
    logic signed [SAMPLE_BITS-1:0] band1_right;
    logic signed [SAMPLE_BITS-1:0] band2_left;
    logic signed [SAMPLE_BITS-1:0] band2_right;
    logic signed [SAMPLE_BITS-1:0] band3_left;
    logic signed [SAMPLE_BITS-1:0] band3_right;
    logic signed [SAMPLE_BITS-1:0] band4_left;
    logic signed [SAMPLE_BITS-1:0] band4_right;
    logic                          last_out;
  } out_item_t;

  // configuration register indexes
  localparam logic [1:0] CFG_LOW  = 2'd0;
  localparam logic [1:0] CFG_MID  = 2'd1;
  localparam logic [1:0] CFG_HIGH = 2'd2;

  // operation codes
  localparam logic [1:0] OP_AP1  = 2'd0;
  localparam logic [1:0] OP_AP2  = 2'd1;
  localparam logic [1:0] OP_HALF = 2'd2;
  localparam logic [1:0] OP_DIFF = 2'd3;

  // last phase of each operation
  localparam logic [2:0] PH_AP1_LAST = 3'd3;
  localparam logic [2:0] PH_AP2_LAST = 3'd4;
  localparam logic [2:0] PH_2OP_LAST = 3'd1;

  // working register codes
  localparam logic [3:0] R_IN = 4'd0;
  localparam logic [3:0] R_A1 = 4'd1;
  localparam logic [3:0] R_A2 = 4'd2;
  localparam logic [3:0] R_S  = 4'd3;
  localparam logic [3:0] R_B1 = 4'd4;
  localparam logic [3:0] R_B2 = 4'd5;
  localparam logic [3:0] R_C  = 4'd6;
  localparam logic [3:0] R_LP = 4'd7;
  localparam logic [3:0] R_HP = 4'd8;
  localparam logic [3:0] R_N  = 4'd9;
  localparam logic [3:0] R_O1 = 4'd10;
  localparam logic [3:0] R_O2 = 4'd11;
  localparam logic [3:0] R_O3 = 4'd12;
  localparam logic [3:0] R_O4 = 4'd13;

  localparam int NUM_WK     = 18;   // left outputs at 10..13, right at 14..17
  localparam int NUM_FO     = 22;
  localparam int NUM_SO     = 32;
  localparam logic [4:0] LAST_PC = 5'd27;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] srca;
    logic [3:0] srcb;
    logic [3:0] dst;
    logic [3:0] fsec;
    logic [2:0] qsec;
    logic [1:0] cs;
  } prog_t;

  typedef struct packed {
    prog_t      pr;
    logic [2:0] ph;
    logic       ch;
    logic       run;
    logic       ld_in;
    logic       ld_x;
    logic       ld_out;
  } cmd_t;

  function automatic prog_t mk(input logic [1:0] op, input logic [3:0] a,
                               input logic [3:0] b, input logic [3:0] d,
                               input logic [3:0] f, input logic [2:0] q,
                               input logic [1:0] cs);
    prog_t p;
    p.op = op; p.srca = a; p.srcb = b; p.dst = d;
    p.fsec = f; p.qsec = q; p.cs = cs;
    return p;
  endfunction

  // per-channel sequence: mid split, low compensation, low split,
  // high compensation, high split
  function automatic prog_t prog_rom(input logic [4:0] pc);
    prog_t p;
    p = '0;
    unique case (pc)
      5'd0:  p = mk(OP_AP1,  R_IN, R_IN, R_A1, 4'd0,  3'd0, CFG_MID);
      5'd1:  p = mk(OP_AP2,  R_IN, R_IN, R_A2, 4'd0,  3'd0, CFG_MID);
      5'd2:  p = mk(OP_HALF, R_A1, R_A2, R_S,  4'd0,  3'd0, CFG_MID);
      5'd3:  p = mk(OP_AP1,  R_S,  R_S,  R_B1, 4'd1,  3'd0, CFG_MID);
      5'd4:  p = mk(OP_AP2,  R_S,  R_S,  R_B2, 4'd0,  3'd1, CFG_MID);
      5'd5:  p = mk(OP_AP1,  R_A2, R_A2, R_C,  4'd2,  3'd0, CFG_MID);
      5'd6:  p = mk(OP_HALF, R_B1, R_B2, R_LP, 4'd0,  3'd0, CFG_MID);
      5'd7:  p = mk(OP_DIFF, R_C,  R_LP, R_HP, 4'd0,  3'd0, CFG_MID);
      5'd8:  p = mk(OP_AP1,  R_LP, R_LP, R_N,  4'd3,  3'd0, CFG_HIGH);
      5'd9:  p = mk(OP_AP2,  R_N,  R_N,  R_N,  4'd0,  3'd2, CFG_HIGH);
      5'd10: p = mk(OP_AP1,  R_N,  R_N,  R_A1, 4'd5,  3'd0, CFG_LOW);
      5'd11: p = mk(OP_AP2,  R_N,  R_N,  R_A2, 4'd0,  3'd4, CFG_LOW);
      5'd12: p = mk(OP_HALF, R_A1, R_A2, R_S,  4'd0,  3'd0, CFG_LOW);
      5'd13: p = mk(OP_AP1,  R_S,  R_S,  R_B1, 4'd6,  3'd0, CFG_LOW);
      5'd14: p = mk(OP_AP2,  R_S,  R_S,  R_B2, 4'd0,  3'd5, CFG_LOW);
      5'd15: p = mk(OP_AP1,  R_A2, R_A2, R_C,  4'd7,  3'd0, CFG_LOW);
      5'd16: p = mk(OP_HALF, R_B1, R_B2, R_O1, 4'd0,  3'd0, CFG_LOW);
      5'd17: p = mk(OP_DIFF, R_C,  R_O1, R_O2, 4'd0,  3'd0, CFG_LOW);
      5'd18: p = mk(OP_AP1,  R_HP, R_HP, R_N,  4'd4,  3'd0, CFG_LOW);
      5'd19: p = mk(OP_AP2,  R_N,  R_N,  R_N,  4'd0,  3'd3, CFG_LOW);
      5'd20: p = mk(OP_AP1,  R_N,  R_N,  R_A1, 4'd8,  3'd0, CFG_HIGH);
      5'd21: p = mk(OP_AP2,  R_N,  R_N,  R_A2, 4'd0,  3'd6, CFG_HIGH);
      5'd22: p = mk(OP_HALF, R_A1, R_A2, R_S,  4'd0,  3'd0, CFG_HIGH);
      5'd23: p = mk(OP_AP1,  R_S,  R_S,  R_B1, 4'd9,  3'd0, CFG_HIGH);
      5'd24: p = mk(OP_AP2,  R_S,  R_S,  R_B2, 4'd0,  3'd7, CFG_HIGH);
      5'd25: p = mk(OP_AP1,  R_A2, R_A2, R_C,  4'd10, 3'd0, CFG_HIGH);
      5'd26: p = mk(OP_HALF, R_B1, R_B2, R_O3, 4'd0,  3'd0, CFG_HIGH);
      5'd27: p = mk(OP_DIFF, R_C,  R_O3, R_O4, 4'd0,  3'd0, CFG_HIGH);
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic signed [ACC_BITS-1:0] sat32(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sd2147483647;
    lo = -36'sd2147483648;
    if (v > hi) return hi[ACC_BITS-1:0];
    if (v < lo) return lo[ACC_BITS-1:0];
    return v[ACC_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_out(
      input logic signed [ACC_BITS-1:0] v);
    logic signed [ACC_BITS-1:0] hi;
    logic signed [ACC_BITS-1:0] lo;
    hi = ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    lo = -hi - ACC_BITS'(1);
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    if (v < lo) return lo[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

[hdl/allpass_four_band_crossover_core.sv]
// Top level of the four-band stereo allpass crossover.
//  port group | direction | transfer when
//  in_*       | input     | in_valid && !in_stall  (stereo sample + last mark)
//  out_*      | output    | out_valid && !out_stall (four stereo bands + last mark)
//  cfg_*      | input     | cfg_wr_en (index 0 low, 1 mid, 2 high cutoff coefs)
// For each channel in turn an item is loaded and then run through 28 sections on the
// single shared multiplier (11 first-order, 8 second-order, 9 sum/difference); the
// result register is loaded after both channels.
// A new item is taken the cycle after the result register is loaded, even if it is
// still stalled; no new item is taken while one is being processed.
// Synchronous active-low reset clears coefficients and all filter states.
module allpass_four_band_crossover_core import apxo_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [CREG_BITS-1:0] cfg_wdata
);

  cmd_t cmd;

  apxo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  apxo_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

[hdl/apxo_ctrl.sv]
// Sequencer: walks the section table per channel and drives datapath commands.
module apxo_ctrl import apxo_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic out_stall,
  output logic out_valid,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LDX  = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [4:0] pc_r, pc_nxt;
  logic [2:0] ph_r, ph_nxt;
  logic       ch_r, ch_nxt;
  logic       out_valid_r, out_valid_nxt;
  prog_t      pr;
  logic [2:0] ph_last;

  assign pr = prog_rom(pc_r);

  always_comb begin
    unique case (pr.op)
      OP_AP1:  ph_last = PH_AP1_LAST;
      OP_AP2:  ph_last = PH_AP2_LAST;
      default: ph_last = PH_2OP_LAST;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    ph_nxt        = ph_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.pr        = pr;
    cmd.ph        = ph_r;
    cmd.ch        = ch_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          ch_nxt    = 1'b0;
          pc_nxt    = '0;
          ph_nxt    = '0;
          state_nxt = S_LDX;
        end
      end
      S_LDX: begin
        cmd.ld_x  = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        cmd.run = 1'b1;
        if (ph_r == ph_last) begin
          ph_nxt = '0;
          if (pc_r == LAST_PC) begin
            pc_nxt = '0;
            if (!ch_r) begin
              ch_nxt    = 1'b1;
              state_nxt = S_LDX;
            end else begin
              state_nxt = S_DONE;
            end
          end else begin
            pc_nxt = pc_r + 5'd1;
          end
        end else begin
          ph_nxt = ph_r + 3'd1;
        end
      end
      S_DONE: begin
        // result register is free once the previous transfer has gone
        if (!out_valid_r || !out_stall) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      ph_r        <= '0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      ph_r        <= ph_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hdl/apxo_dp.sv]
// Datapath: coefficient registers, filter states, working registers and one shared MAC.
module apxo_dp import apxo_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  input  in_item_t             in_data,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [CREG_BITS-1:0] cfg_wdata,
  output out_item_t            out_data
);

  logic [CREG_BITS-1:0] low_r, mid_r, high_r, coef;
  logic signed [COEF_BITS-1:0] k0, k1, k2, mul_k;

  logic signed [ACC_BITS-1:0] fo_r [0:NUM_FO-1];
  logic signed [ACC_BITS-1:0] so_r [0:NUM_SO-1];
  logic signed [ACC_BITS-1:0] wk_r [0:NUM_WK-1];

  in_item_t  in_r;
  out_item_t out_r;

  logic signed [RND_BITS-1:0] m_r, m_nxt;
  logic signed [ACC_BITS-1:0] s_r, s_nxt, t_r, t_nxt;
  logic signed [RND_BITS:0]   acc_r, acc_nxt;

  logic [3:0] rd_code;
  logic [4:0] rd_idx, wr_idx, fo_idx, so_idx;
  logic       so_j;
  logic signed [ACC_BITS-1:0] xv, fo_rd, so_rd, mul_a;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [RND_BITS-1:0]  rnd;
  logic signed [ACC_BITS:0]    hsum;

  logic                       fo_we, so_we, wk_we;
  logic signed [ACC_BITS-1:0] fo_wd, so_wd, wk_wd;

  function automatic logic [4:0] phys(input logic [3:0] code, input logic ch);
    if (ch && code >= R_O1) return 5'(code) + 5'd4;
    return 5'(code);
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      mid_r  <= '0;
      high_r <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_LOW)  low_r  <= cfg_wdata;
      if (cfg_index == CFG_MID)  mid_r  <= cfg_wdata;
      if (cfg_index == CFG_HIGH) high_r <= cfg_wdata;
    end
  end

  always_comb begin
    unique case (cmd.pr.cs)
      CFG_LOW:  coef = low_r;
      CFG_MID:  coef = mid_r;
      CFG_HIGH: coef = high_r;
      default:  coef = low_r;
    endcase
  end

  assign k0 = coef[COEF_BITS-1:0];
  assign k1 = coef[2*COEF_BITS-1:COEF_BITS];
  assign k2 = coef[3*COEF_BITS-1:2*COEF_BITS];

  // operand fetch: HALF/DIFF read the second operand in their second phase
  assign rd_code = ((cmd.pr.op == OP_HALF || cmd.pr.op == OP_DIFF) && cmd.ph == 3'd1)
                   ? cmd.pr.srcb : cmd.pr.srca;
  assign rd_idx  = phys(rd_code, cmd.ch);
  assign wr_idx  = phys(cmd.pr.dst, cmd.ch);
  assign xv      = wk_r[rd_idx];

  assign fo_idx = {cmd.pr.fsec, cmd.ch};
  assign so_j   = (cmd.ph == 3'd2) || (cmd.ph == 3'd4);
  assign so_idx = {cmd.pr.qsec, cmd.ch, so_j};
  assign fo_rd  = fo_r[fo_idx];
  assign so_rd  = so_r[so_idx];

  // shared multiplier with round-half-up scaling
  always_comb begin
    mul_a = xv;
    mul_k = k0;
    if (cmd.pr.op == OP_AP1) begin
      mul_a = (cmd.ph == 3'd0) ? fo_rd : t_r;
      mul_k = k0;
    end else begin
      unique case (cmd.ph)
        3'd0:    begin mul_a = xv;  mul_k = k2; end
        3'd1:    begin mul_a = xv;  mul_k = k1; end
        3'd2:    begin mul_a = s_r; mul_k = k1; end
        default: begin mul_a = s_r; mul_k = k2; end
      endcase
    end
  end

  assign prod = PROD_BITS'(mul_a) * PROD_BITS'(mul_k)
                + PROD_BITS'(64'sd1 <<< (CFRAC - 1));
  assign rnd  = prod[PROD_BITS-1:CFRAC];
  assign hsum = (ACC_BITS+1)'(t_r) + (ACC_BITS+1)'(xv);

  always_comb begin
    m_nxt   = m_r;
    s_nxt   = s_r;
    t_nxt   = t_r;
    acc_nxt = acc_r;
    fo_we   = 1'b0;
    so_we   = 1'b0;
    wk_we   = 1'b0;
    fo_wd   = '0;
    so_wd   = '0;
    wk_wd   = '0;
    if (cmd.run) begin
      unique case (cmd.pr.op)
        OP_AP1: begin
          unique case (cmd.ph)
            3'd0: begin m_nxt = rnd; s_nxt = fo_rd; end
            3'd1: begin
              fo_we = 1'b1;
              fo_wd = sat32(36'(xv) - 36'(m_r));
              t_nxt = fo_wd;
            end
            3'd2: m_nxt = rnd;
            default: begin
              wk_we = 1'b1;
              wk_wd = sat32(36'(m_r) + 36'(s_r));
            end
          endcase
        end
        OP_AP2: begin
          unique case (cmd.ph)
            3'd0: begin m_nxt = rnd; t_nxt = so_rd; end
            3'd1: begin m_nxt = rnd; s_nxt = sat32(36'(m_r) + 36'(t_r)); end
            3'd2: begin
              m_nxt   = rnd;
              acc_nxt = (RND_BITS+1)'(m_r) + (RND_BITS+1)'(so_rd);
            end
            3'd3: begin
              m_nxt = rnd;
              so_we = 1'b1;
              so_wd = sat32(36'(acc_r) - 36'(m_r));
            end
            default: begin
              so_we = 1'b1;
              so_wd = sat32(36'(xv) - 36'(m_r));
              wk_we = 1'b1;
              wk_wd = s_r;
            end
          endcase
        end
        OP_HALF: begin
          if (cmd.ph == 3'd0) begin
            t_nxt = xv;
          end else begin
            wk_we = 1'b1;
            wk_wd = hsum[ACC_BITS:1];
          end
        end
        default: begin
          if (cmd.ph == 3'd0) begin
            t_nxt = xv;
          end else begin
            wk_we = 1'b1;
            wk_wd = sat32(36'(t_r) - 36'(xv));
          end
        end
      endcase
    end
  end

  // filter state, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FO; i++) fo_r[i] <= '0;
      for (int i = 0; i < NUM_SO; i++) so_r[i] <= '0;
    end else begin
      if (fo_we) fo_r[fo_idx] <= fo_wd;
      if (so_we) so_r[so_idx] <= so_wd;
    end
  end

  always_ff @(posedge clk) begin
    m_r   <= m_nxt;
    s_r   <= s_nxt;
    t_r   <= t_nxt;
    acc_r <= acc_nxt;
    if (cmd.ld_in) in_r <= in_data;
    if (cmd.ld_x) begin
      wk_r[0] <= cmd.ch ? ACC_BITS'(in_r.right_in) : ACC_BITS'(in_r.left_in);
    end else if (wk_we) begin
      wk_r[wr_idx] <= wk_wd;
    end
    if (cmd.ld_out) begin
      out_r.band1_left  <= sat_out(wk_r[10]);
      out_r.band2_left  <= sat_out(wk_r[11]);
      out_r.band3_left  <= sat_out(wk_r[12]);
      out_r.band4_left  <= sat_out(wk_r[13]);
      out_r.band1_right <= sat_out(wk_r[14]);
      out_r.band2_right <= sat_out(wk_r[15]);
      out_r.band3_right <= sat_out(wk_r[16]);
      out_r.band4_right <= sat_out(wk_r[17]);
      out_r.last_out    <= in_r.last_in;
    end
  end

  assign out_data = out_r;

endmodule

[verif/tb_allpass_four_band_crossover_core.sv]
// Testbench for the four-band allpass crossover core with a scoreboard and random flow control.
`timescale 1ns / 100ps

module tb_allpass_four_band_crossover_core;
  import apxo_pkg::*;

  localparam int ITEM_LATENCY = 210;
  localparam int IDLE_LIMIT   = 20000;

  class band_scoreboard;
    logic [CREG_BITS-1:0] coefs [3];
    longint fo [NUM_FO];
    longint so [NUM_SO];
    out_item_t pending [$];
    int errors;

    function void clear();
      foreach (coefs[i]) coefs[i] = '0;
      foreach (fo[i]) fo[i] = 0;
      foreach (so[i]) so[i] = 0;
      pending.delete();
      errors = 0;
    endfunction

    function longint clip(longint v, int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function longint kval(int reg_sel, int n);
      logic signed [COEF_BITS-1:0] k;
      k = coefs[reg_sel][n*COEF_BITS +: COEF_BITS];
      return longint'(k);
    endfunction

    function longint mul_round(longint a, longint k);
      return (a * k + (longint'(1) << (CFRAC - 1))) >>> CFRAC;
    endfunction

    function longint first_order(longint x, longint k0, int idx);
      longint v, y;
      v = clip(x - mul_round(fo[idx], k0), 32);
      y = clip(mul_round(v, k0) + fo[idx], 32);
      fo[idx] = v;
      return y;
    endfunction

    function longint second_order(longint x, longint k1, longint k2, int idx);
      longint y;
      y = clip(mul_round(x, k2) + so[idx], 32);
      so[idx] = clip(mul_round(x, k1) + so[idx+1] - mul_round(y, k1), 32);
      so[idx+1] = clip(x - mul_round(y, k2), 32);
      return y;
    endfunction

    function void band_split(longint x, int reg_sel, int f, int q, int ch,
                             output longint lp, output longint hp);
      longint k0, k1, k2, a1, a2, s, b1, b2, c;
      k0 = kval(reg_sel, 0); k1 = kval(reg_sel, 1); k2 = kval(reg_sel, 2);
      a1 = first_order(x, k0, f*2 + ch);
      a2 = second_order(x, k1, k2, q*4 + ch*2);
      s  = (a1 + a2) >>> 1;
      b1 = first_order(s, k0, (f+1)*2 + ch);
      b2 = second_order(s, k1, k2, (q+1)*4 + ch*2);
      c  = first_order(a2, k0, (f+2)*2 + ch);
      lp = (b1 + b2) >>> 1;
      hp = clip(c - lp, 32);
    endfunction

    function longint phase_align(longint x, int reg_sel, int f, int q, int ch);
      longint y;
      y = first_order(x, kval(reg_sel, 0), f*2 + ch);
      return second_order(y, kval(reg_sel, 1), kval(reg_sel, 2), q*4 + ch*2);
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      longint x, lp, hp, n, b1, b2, b3, b4;
      logic signed [SAMPLE_BITS-1:0] o [4];
      for (int ch = 0; ch < 2; ch++) begin
        x = (ch == 0) ? longint'(it.left_in) : longint'(it.right_in);
        band_split(x, CFG_MID, 0, 0, ch, lp, hp);
        n = phase_align(lp, CFG_HIGH, 3, 2, ch);
        band_split(n, CFG_LOW, 5, 4, ch, b1, b2);
        n = phase_align(hp, CFG_LOW, 4, 3, ch);
        band_split(n, CFG_HIGH, 8, 6, ch, b3, b4);
        o[0] = SAMPLE_BITS'(clip(b1, SAMPLE_BITS));
        o[1] = SAMPLE_BITS'(clip(b2, SAMPLE_BITS));
        o[2] = SAMPLE_BITS'(clip(b3, SAMPLE_BITS));
        o[3] = SAMPLE_BITS'(clip(b4, SAMPLE_BITS));
        if (ch == 0) begin
          r.band1_left = o[0]; r.band2_left = o[1];
          r.band3_left = o[2]; r.band4_left = o[3];
        end else begin
          r.band1_right = o[0]; r.band2_right = o[1];
          r.band3_right = o[2]; r.band4_right = o[3];
        end
      end
      r.last_out = it.last_in;
      pending.push_back(r);
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("result with no expected sample pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("band1_left", e.band1_left, got.band1_left);
      cmp("band1_right", e.band1_right, got.band1_right);
      cmp("band2_left", e.band2_left, got.band2_left);
      cmp("band2_right", e.band2_right, got.band2_right);
      cmp("band3_left", e.band3_left, got.band3_left);
      cmp("band3_right", e.band3_right, got.band3_right);
      cmp("band4_left", e.band4_left, got.band4_left);
      cmp("band4_right", e.band4_right, got.band4_right);
      cmp("last_out", e.last_out, got.last_out);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = CFG_LOW;
  logic [CREG_BITS-1:0] cfg_wdata = '0;

  band_scoreboard sb;
  bit steady = 1'b0;      // no idling on either side
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  allpass_four_band_crossover_core i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_wr_en, .cfg_index, .cfg_wdata
  );

  function automatic bit take_gap();
    return !steady && ($urandom_range(99) < 29);
  endfunction

  // result side: random stall, check every transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= take_gap();
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_coefs(logic [1:0] idx, logic [CREG_BITS-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx <= CFG_HIGH) sb.coefs[idx] = val;
    @(posedge clk);
  endtask

  // valid stays up after the transfer; the next sample replaces the data or drain() drops it
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] l,
                             logic signed [SAMPLE_BITS-1:0] r, logic last);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{left_in: l, right_in: r, last_in: last};
    do @(posedge clk); while (in_stall);
    sb.note_input(in_data);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (ITEM_LATENCY) @(posedge clk);
  endtask

  function automatic logic [COEF_BITS-1:0] rand_coef();
    // mostly stable range |k| <= 1, sometimes anything
    if ($urandom_range(3) == 0) return COEF_BITS'($urandom);
    return COEF_BITS'($signed($urandom_range(131071)) - 65535);
  endfunction

  function automatic logic [CREG_BITS-1:0] rand_reg();
    return {rand_coef(), rand_coef(), rand_coef()};
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(7))
      0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      2: return SAMPLE_BITS'($signed($urandom_range(512)) - 256);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      send_sample(rand_sample(), rand_sample(), $urandom_range(15) == 0);
  endtask

  initial begin
    logic [CREG_BITS-1:0] typical;
    sb = new();
    sb.clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero coefficients, then a typical setting, extremes of samples
    send_sample('0, '0, 1'b0);
    send_sample({1'b0, {23{1'b1}}}, {1'b1, 23'd0}, 1'b1);
    drain();
    typical = {18'sh0C000, -18'sh08000, 18'sh04000};
    write_coefs(CFG_LOW, typical);
    write_coefs(CFG_MID, {18'sh02000, 18'sh3F000, -18'sh06000});
    write_coefs(CFG_HIGH, {-18'sh0A000, 18'sh05000, 18'sh09000});
    write_coefs(2'd3, '1);  // out-of-range index is ignored
    send_sample({1'b0, {23{1'b1}}}, {1'b0, {23{1'b1}}}, 1'b0);
    send_sample({1'b1, 23'd0}, {1'b1, 23'd0}, 1'b0);
    for (int i = 0; i < 6; i++) send_sample('0, '0, i[0]);
    for (int i = 0; i < 4; i++)
      send_sample({1'b0, {23{1'b1}}}, {1'b1, 23'd0}, 1'b0);
    drain();
    // coefficient extremes drive internal saturation
    write_coefs(CFG_LOW, '1);
    write_coefs(CFG_MID, {18'h1FFFF, 18'h20000, 18'h1FFFF});
    write_coefs(CFG_HIGH, {3{18'h20000}});
    for (int i = 0; i < 8; i++)
      send_sample(i[0] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}}, '1, i == 7);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_coefs(CFG_LOW, rand_reg());
      write_coefs(CFG_MID, rand_reg());
      write_coefs(CFG_HIGH, rand_reg());
      steady = (p == 2);
      random_phase(235);
      drain();
    end
    steady = 1'b0;

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
